FILE: hw/rtl/b64lb_pkg.sv
// Package for the base64 encoder with line breaks.
// Holds the line length, character codes, the queued group record and the alphabet function.
// No dependencies.
package b64lb_pkg;

    localparam int LINE_CHARS      = 76;
    localparam int GROUPS_PER_LINE = LINE_CHARS / 4;
    localparam int GROUP_W         = 5;

    localparam logic [7:0] CHAR_PAD     = 8'h3D;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    localparam logic [1:0] PHASE_EMPTY = 2'd0;
    localparam logic [1:0] PHASE_ONE   = 2'd1;
    localparam logic [1:0] PHASE_TWO   = 2'd2;

    // One finished group: four characters, an optional newline and the end flag.
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic            newline;
        logic            last;
    } t_job;

    // Occupancy of the group queue as seen by the front and back parts.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Maps a 6-bit value to its symbol in the standard alphabet.
    function automatic logic [7:0] sym(input logic [5:0] v);
        logic [7:0] res;
        if (v < 6'd26) begin
            res = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            res = 8'h61 + {2'b00, v - 6'd26};
        end else if (v < 6'd62) begin
            res = 8'h30 + {2'b00, v - 6'd52};
        end else if (v == 6'd62) begin
            res = 8'h2B;
        end else begin
            res = 8'h2F;
        end
        return res;
    endfunction

endpackage

FILE: hw/rtl/b64lb_front.sv
// Front part of the encoder: collects bytes into groups and builds the group record.
// Holds the newline enable register and the line counter. Depends on b64lb_pkg.
module b64lb_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    input  logic              i_accept,
    input  logic [7:0]        i_in_byte,
    input  logic              i_in_last,
    output logic              o_job_push,
    output b64lb_pkg::t_job   o_job
);
    import b64lb_pkg::*;

    logic [1:0]         r_phase, n_phase;
    logic [7:0]         r_b0, n_b0;
    logic [7:0]         r_b1, n_b1;
    logic [GROUP_W-1:0] r_groups, n_groups;
    logic               r_nl_en;
    logic               wrap;
    logic [GROUP_W:0]   groups_inc;

    assign groups_inc = {1'b0, r_groups} + {{GROUP_W{1'b0}}, 1'b1};
    assign wrap = groups_inc >= (GROUP_W + 1)'(GROUPS_PER_LINE);

    always_comb begin
        n_phase    = r_phase;
        n_b0       = r_b0;
        n_b1       = r_b1;
        n_groups   = r_groups;
        o_job_push = 1'b0;
        o_job      = '0;
        o_job.last = i_in_last;
        case (r_phase)
            PHASE_ONE: begin
                o_job.chars[0] = sym(r_b0[7:2]);
                o_job.chars[1] = sym({r_b0[1:0], i_in_byte[7:4]});
                o_job.chars[2] = sym({i_in_byte[3:0], 2'b00});
                o_job.chars[3] = CHAR_PAD;
                if (i_accept) begin
                    if (i_in_last) begin
                        o_job_push = 1'b1;
                        n_phase    = PHASE_EMPTY;
                        n_groups   = '0;
                    end else begin
                        n_b1    = i_in_byte;
                        n_phase = PHASE_TWO;
                    end
                end
            end
            PHASE_TWO: begin
                o_job.chars[0] = sym(r_b0[7:2]);
                o_job.chars[1] = sym({r_b0[1:0], r_b1[7:4]});
                o_job.chars[2] = sym({r_b1[3:0], i_in_byte[7:6]});
                o_job.chars[3] = sym(i_in_byte[5:0]);
                o_job.newline  = wrap && r_nl_en;
                if (i_accept) begin
                    o_job_push = 1'b1;
                    n_phase    = PHASE_EMPTY;
                    n_groups   = (i_in_last || wrap) ? '0 : groups_inc[GROUP_W-1:0];
                end
            end
            default: begin
                // An unused phase code behaves like an empty group.
                o_job.chars[0] = sym(i_in_byte[7:2]);
                o_job.chars[1] = sym({i_in_byte[1:0], 4'b0000});
                o_job.chars[2] = CHAR_PAD;
                o_job.chars[3] = CHAR_PAD;
                if (i_accept) begin
                    if (i_in_last) begin
                        o_job_push = 1'b1;
                        n_phase    = PHASE_EMPTY;
                        n_groups   = '0;
                    end else begin
                        n_b0    = i_in_byte;
                        n_phase = PHASE_ONE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PHASE_EMPTY;
            r_groups <= '0;
            r_nl_en  <= 1'b0;
            r_b0     <= '0;
            r_b1     <= '0;
        end else begin
            r_phase  <= n_phase;
            r_groups <= n_groups;
            r_b0     <= n_b0;
            r_b1     <= n_b1;
            if (i_cfg_we) begin
                r_nl_en <= i_cfg_wdata;
            end
        end
    end

endmodule

FILE: hw/rtl/b64lb_queue.sv
// Two-entry queue of group records between the front and back parts.
// Depends on b64lb_pkg.
module b64lb_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  b64lb_pkg::t_job      i_job,
    input  logic                 i_pop,
    output b64lb_pkg::t_job      o_job,
    output b64lb_pkg::t_q_status o_status
);
    import b64lb_pkg::*;

    t_job       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_status.full  = r_count == 2'd2;
    assign o_status.empty = r_count == 2'd0;
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: hw/rtl/b64lb_back.sv
// Encoder back part: sends queued groups' characters one per cycle while its output
// register, read by the result side, is empty or popped. Depends on b64lb_pkg.
module b64lb_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  b64lb_pkg::t_job      i_job,
    input  b64lb_pkg::t_q_status i_q_status,
    output logic                 o_job_pop,
    input  logic                 i_pop,
    output logic                 o_empty,
    output logic [7:0]           o_out_char,
    output logic                 o_out_last
);
    import b64lb_pkg::*;

    logic [2:0] r_idx;
    logic       r_valid;
    logic [7:0] r_char;
    logic       r_last;
    logic       load;
    logic       advance;
    logic       final_char;
    logic [7:0] cur_char;

    // The output register takes a new character when it is empty or being read.
    assign load       = !r_valid || i_pop;
    assign advance    = load && !i_q_status.empty;
    assign final_char = i_job.newline ? (r_idx == 3'd4) : (r_idx == 3'd3);
    assign cur_char   = (r_idx == 3'd4) ? CHAR_NEWLINE : i_job.chars[r_idx[1:0]];
    assign o_job_pop  = advance && final_char;

    assign o_empty    = !r_valid;
    assign o_out_char = r_char;
    assign o_out_last = r_last;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_char <= cur_char;
            r_last <= i_job.last && final_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 3'd0;
            r_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_valid <= 1'b1;
                r_idx   <= final_char ? 3'd0 : r_idx + 3'd1;
            end else if (load) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

FILE: hw/rtl/base64_encoder_line_breaks_top.sv
// Channel   | Direction | Handshake     | Payload
// input     | in        | push / full   | i_in_byte, i_in_last
// result    | out       | empty / pop   | o_out_char, o_out_last
// config    | in        | i_cfg_we      | i_cfg_wdata (newline enable)
//
// Up to one byte is accepted each cycle while the group queue has room.
// Characters leave at one per cycle while pop keeps the back part's output register draining, so
// a three-byte group drains as four characters, or five with a newline; sustained rate is set by that port.
// Reset is synchronous and active low and clears the group state and the queue.
// A stall on pop fills the two-entry queue, after which full holds off further bytes.
// Depends on b64lb_pkg, b64lb_front, b64lb_queue and b64lb_back.
module base64_encoder_line_breaks_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_char,
    output logic       o_out_last
);
    import b64lb_pkg::*;

    t_job      front_job;
    t_job      head_job;
    t_q_status q_status;
    logic      job_push;
    logic      job_pop;
    logic      accept;

    assign full   = q_status.full;
    assign accept = push && !q_status.full;

    b64lb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_in_byte   (i_in_byte),
        .i_in_last   (i_in_last),
        .o_job_push  (job_push),
        .o_job       (front_job)
    );

    b64lb_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (job_push),
        .i_job    (front_job),
        .i_pop    (job_pop),
        .o_job    (head_job),
        .o_status (q_status)
    );

    b64lb_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (head_job),
        .i_q_status (q_status),
        .o_job_pop  (job_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_out_char (o_out_char),
        .o_out_last (o_out_last)
    );

endmodule
